// File: rtl/ivs_pkg.sv
// Package for the indexed vector store: capacity and widths, request and
// result word types, mode and status codes, and sequencer states.
// No dependencies; used by rtl/indexed_vector_store.sv.
package ivs_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned DATA_WIDTH = 32;

  // Widths fixed by the request and result words.
  localparam int unsigned MODE_W = 2;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned RD_W   = 32;
  localparam int unsigned CNT_W  = 7;

  // Internal widths derived from the capacity.
  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned LIVE_W = $clog2(CAPACITY + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_READ   = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_DELETE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEL_RD,
    S_DEL_WR,
    S_RESP
  } state_e;

  typedef struct packed {
    mode_e             mode;
    logic [IDX_W-1:0]  index;
    logic [VAL_W-1:0]  value;
  } in_word_t;

  typedef struct packed {
    logic [RD_W-1:0]   read_data;
    status_e           status;
    logic [CNT_W-1:0]  count;
  } out_word_t;

endpackage

// File: rtl/indexed_vector_store.sv
// Indexed vector store top level: sequencer, entry memory and result register.
// Depends on ivs_pkg.

// A bounded vector of data words with a live count. Each request word either
// appends a value, reads or overwrites the entry at an index, or deletes the
// entry at an index and moves every later entry down one place. The block
// takes one request at a time and holds in_stall_o high while it works.
// Append, read, write and any refused request pass through the execute
// state and then the result state, which loads the output register; the
// sequencer then returns to idle, where the next request can be accepted.
// A delete with entries after its index goes from the execute state
// through a read state and a write state for each entry moved on the
// entry memory, and then to the result state; one pointer register and
// one compare drive the moves. A finished result waits in its own output
// register, so the next request is accepted while it is still stalled; the
// result state of that next request waits until the register is free. There
// is no clearing pass after reset; entries hold nothing meaningful until
// written, and only written entries are ever reachable.
module indexed_vector_store (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ivs_pkg::in_word_t    in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ivs_pkg::out_word_t   out_word_o
);

  ivs_pkg::state_e state_q, state_d;
  ivs_pkg::in_word_t req_q;
  ivs_pkg::status_e status_q, status_d;
  logic [ivs_pkg::LIVE_W-1:0] count_q, count_d;
  logic [ivs_pkg::ADDR_W-1:0] ptr_q, ptr_d;
  logic out_valid_q;
  ivs_pkg::out_word_t out_q;

  logic [ivs_pkg::DATA_WIDTH-1:0] mem [ivs_pkg::CAPACITY];
  logic [ivs_pkg::DATA_WIDTH-1:0] rdata_q;
  logic                           mem_we, mem_re;
  logic [ivs_pkg::ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [ivs_pkg::DATA_WIDTH-1:0] mem_wdata;

  logic [ivs_pkg::LIVE_W-1:0] idx_ext;
  logic                       hit;
  logic                       not_full;
  logic                       more_shift;
  logic                       out_free;
  logic                       accept;

  assign idx_ext  = ivs_pkg::LIVE_W'(req_q.index);
  assign hit      = (idx_ext < count_q)
                    && (idx_ext < ivs_pkg::LIVE_W'(ivs_pkg::CAPACITY));
  assign not_full = count_q < ivs_pkg::LIVE_W'(ivs_pkg::CAPACITY);
  // Shared pointer unit: the next move exists while ptr + 2 < count.
  assign more_shift = (ivs_pkg::LIVE_W'(ptr_q) + ivs_pkg::LIVE_W'(2)) < count_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = state_q != ivs_pkg::S_IDLE;
  assign accept     = in_valid_i && !in_stall_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ivs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = ivs_pkg::S_EXEC;
        end
      end
      ivs_pkg::S_EXEC: begin
        if (req_q.mode == ivs_pkg::MODE_DELETE && hit &&
            (idx_ext + ivs_pkg::LIVE_W'(1)) < count_q) begin
          state_d = ivs_pkg::S_DEL_RD;
        end else begin
          state_d = ivs_pkg::S_RESP;
        end
      end
      ivs_pkg::S_DEL_RD: state_d = ivs_pkg::S_DEL_WR;
      ivs_pkg::S_DEL_WR: begin
        state_d = more_shift ? ivs_pkg::S_DEL_RD : ivs_pkg::S_RESP;
      end
      ivs_pkg::S_RESP: begin
        if (out_free) begin
          state_d = ivs_pkg::S_IDLE;
        end
      end
      default: state_d = ivs_pkg::S_IDLE;
    endcase
  end

  // Datapath control and memory port selection.
  always_comb begin
    count_d   = count_q;
    ptr_d     = ptr_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = req_q.index[ivs_pkg::ADDR_W-1:0];
    mem_raddr = req_q.index[ivs_pkg::ADDR_W-1:0];
    mem_wdata = ivs_pkg::DATA_WIDTH'(req_q.value);
    case (state_q)
      ivs_pkg::S_EXEC: begin
        status_d = ivs_pkg::ST_DONE;
        ptr_d    = req_q.index[ivs_pkg::ADDR_W-1:0];
        case (req_q.mode)
          ivs_pkg::MODE_APPEND: begin
            if (not_full) begin
              mem_we    = 1'b1;
              mem_waddr = count_q[ivs_pkg::ADDR_W-1:0];
              count_d   = count_q + ivs_pkg::LIVE_W'(1);
            end else begin
              status_d = ivs_pkg::ST_FULL;
            end
          end
          ivs_pkg::MODE_READ: begin
            if (hit) begin
              mem_re = 1'b1;
            end else begin
              status_d = ivs_pkg::ST_RANGE;
            end
          end
          ivs_pkg::MODE_WRITE: begin
            if (hit) begin
              mem_we = 1'b1;
            end else begin
              status_d = ivs_pkg::ST_RANGE;
            end
          end
          ivs_pkg::MODE_DELETE: begin
            if (!hit) begin
              status_d = ivs_pkg::ST_RANGE;
            end else if ((idx_ext + ivs_pkg::LIVE_W'(1)) >= count_q) begin
              // Deleting the last entry moves nothing.
              count_d = count_q - ivs_pkg::LIVE_W'(1);
            end
          end
          default: status_d = ivs_pkg::ST_DONE;
        endcase
      end
      ivs_pkg::S_DEL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_q + ivs_pkg::ADDR_W'(1);
      end
      ivs_pkg::S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = rdata_q;
        if (more_shift) begin
          ptr_d = ptr_q + ivs_pkg::ADDR_W'(1);
        end else begin
          count_d = count_q - ivs_pkg::LIVE_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ivs_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == ivs_pkg::S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_word_i;
    end
    ptr_q    <= ptr_d;
    status_q <= status_d;
    if (state_q == ivs_pkg::S_RESP && out_free) begin
      out_q.status <= status_q;
      out_q.count  <= ivs_pkg::CNT_W'(count_q);
      if (req_q.mode == ivs_pkg::MODE_READ && status_q == ivs_pkg::ST_DONE) begin
        out_q.read_data <= ivs_pkg::RD_W'(rdata_q);
      end else begin
        out_q.read_data <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ivs_pkg::LIVE_W'(ivs_pkg::CAPACITY))
    else $error("live count above capacity");

  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ($past(state_q) == ivs_pkg::S_EXEC || $past(state_q) == ivs_pkg::S_DEL_WR))
    else $error("live count changed outside an update step");

  a_shift_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ivs_pkg::S_DEL_RD) |->
      ((ivs_pkg::LIVE_W'(ptr_q) + ivs_pkg::LIVE_W'(1)) < count_q))
    else $error("delete shift reads beyond the live entries");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ivs_pkg::S_RESP))
    else $error("result word raised without a finished request");
`endif

endmodule
